// ===== hdl/sstm_pkg.sv =====
package sstm_pkg;

  localparam int RECORDS_DEF = 15;
  localparam int SLOTS_DEF   = 8;

  localparam int SEG_W  = 12;
  localparam int DESC_W = 32;
  localparam int STAT_W = 3;

  localparam logic [SEG_W-1:0] SEG_RESERVED = 12'h800;
  localparam logic [SEG_W-1:0] SEG_ZERO     = 12'h000;

  // result status codes
  localparam logic [STAT_W-1:0] ST_RESIDENT   = 3'd0;
  localparam logic [STAT_W-1:0] ST_RELOADED   = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND  = 3'd2;
  localparam logic [STAT_W-1:0] ST_REGISTERED = 3'd3;
  localparam logic [STAT_W-1:0] ST_SKIPPED    = 3'd4;
  localparam logic [STAT_W-1:0] ST_FULL       = 3'd5;

  // transaction kinds
  localparam logic KIND_REGISTER = 1'b0;
  localparam logic KIND_RELOAD   = 1'b1;

  // first-level entry types
  localparam logic [1:0] ET_INVALID = 2'd0;
  localparam logic [1:0] ET_COARSE  = 2'd1;
  localparam logic [1:0] ET_SECTION = 2'd2;
  localparam logic [1:0] ET_FINE    = 2'd3;

  localparam logic [31:0] MASK_COARSE  = 32'hFFFF_FC00;
  localparam logic [31:0] MASK_SECTION = 32'hFFF0_0000;
  localparam logic [31:0] MASK_FINE    = 32'hFFFF_F000;
  localparam logic [31:0] DESC_BIT4    = 32'h0000_0010;

  function automatic logic [DESC_W-1:0] pack_desc(
    input logic [1:0]  etype,
    input logic [31:0] addr,
    input logic [3:0]  dom,
    input logic [1:0]  ap,
    input logic        c,
    input logic        b
  );
    logic [DESC_W-1:0] d;
    d = '0;
    case (etype)
      ET_COARSE: begin
        d = (addr & MASK_COARSE) | {23'd0, dom, 5'd0} | DESC_BIT4 | 32'd1;
      end
      ET_SECTION: begin
        d = (addr & MASK_SECTION) | {20'd0, ap, 10'd0} | {23'd0, dom, 5'd0}
          | DESC_BIT4 | {28'd0, c, b, 2'd0} | 32'd2;
      end
      ET_FINE: begin
        d = (addr & MASK_FINE) | {23'd0, dom, 5'd0} | DESC_BIT4 | 32'd3;
      end
      default: begin
        d = '0;
      end
    endcase
    return d;
  endfunction

endpackage

// ===== hdl/sstm_records.sv =====
module sstm_records #(
  parameter int RECORDS = sstm_pkg::RECORDS_DEF,
  parameter int RW      = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [RW-1:0]             rd_addr,
  output logic                      rd_valid,
  output logic [sstm_pkg::SEG_W-1:0]  rd_seg,
  output logic [sstm_pkg::DESC_W-1:0] rd_desc,
  input  logic                      wr_en,
  input  logic [RW-1:0]             wr_addr,
  input  logic [sstm_pkg::SEG_W-1:0]  wr_seg,
  input  logic [sstm_pkg::DESC_W-1:0] wr_desc
);
  import sstm_pkg::*;

  logic [SEG_W-1:0]  seg_mem  [RECORDS];
  logic [DESC_W-1:0] desc_mem [RECORDS];
  logic [RECORDS-1:0] valid;

  // occupancy bits: cleared by reset, an empty record reads as not valid
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      rd_valid <= valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      seg_mem[wr_addr]  <= wr_seg;
      desc_mem[wr_addr] <= wr_desc;
    end
    rd_seg  <= seg_mem[rd_addr];
    rd_desc <= desc_mem[rd_addr];
  end

endmodule

// ===== hdl/sstm_slots.sv =====
module sstm_slots #(
  parameter int SLOTS = sstm_pkg::SLOTS_DEF,
  parameter int SW    = 3
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [SW-1:0]            rd_idx,
  output logic [sstm_pkg::SEG_W-1:0] rd_seg,
  input  logic                     take,
  input  logic [sstm_pkg::SEG_W-1:0] take_seg,
  output logic [SW-1:0]            ptr
);
  import sstm_pkg::*;

  localparam logic [SW-1:0] LAST  = SW'(SLOTS - 1);
  localparam logic [SW-1:0] FIRST = SW'(1);

  logic [SEG_W-1:0] loc [SLOTS];
  logic [SW-1:0]    ptr_next;

  assign rd_seg   = loc[rd_idx];
  assign ptr_next = (ptr == LAST) ? FIRST : ptr + FIRST;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        loc[i] <= '0;
      end
      ptr <= FIRST;
    end else if (take) begin
      loc[ptr] <= take_seg;
      ptr      <= ptr_next;
    end
  end

endmodule

// ===== hdl/segment_slot_translation_manager.sv =====
// A register transaction for segment 0 or the reserved segment skips both scans; any other
//   register scans the records, and a reload checks the slots and, if not resident, the records.
// Throughput: one transaction at a time; the single segment comparator walks slots 1..SLOTS-1
//   one per cycle, then the record store one entry per cycle through its read port. The next
//   transaction is taken the cycle after the result is loaded.
// Reset (rst, synchronous, active high): records empty, all slots hold segment 0,
//   slot pointer 1, no result pending. Record descriptors are not cleared.
module segment_slot_translation_manager #(
  parameter int RECORDS = sstm_pkg::RECORDS_DEF,
  parameter int SLOTS   = sstm_pkg::SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input transaction
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [11:0] segment, [13:12] entry_type, [45:14] target_address, [49:46] domain,
  // [51:50] access_perm, [52] cacheable, [53] bufferable, [55:54] zero
  input  logic [55:0] s_axis_tdata,
  // [0] kind
  input  logic        s_axis_tuser,
  // result transaction
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] slot, [3] slot_written, [35:4] descriptor, [36] descriptor_valid, [39:37] zero
  output logic [39:0] m_axis_tdata,
  // [2:0] status
  output logic [2:0]  m_axis_tuser
);
  import sstm_pkg::*;

  localparam int RW = (RECORDS > 1) ? $clog2(RECORDS) : 1;
  localparam int SW = $clog2(SLOTS);

  localparam logic [RW-1:0] REC_LAST  = RW'(RECORDS - 1);
  localparam logic [SW-1:0] SLOT_LAST = SW'(SLOTS - 1);
  localparam logic [SW-1:0] SLOT_ONE  = SW'(1);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SLOT = 2'd1;  // resident check over slots
  localparam logic [1:0] S_REC  = 2'd2;  // record scan, compare in the cycle after each read
  localparam logic [1:0] S_DONE = 2'd3;  // hand result to output register

  logic [1:0]        state;
  logic              kind;
  logic [SEG_W-1:0]  seg;
  logic [DESC_W-1:0] desc;
  logic [SW-1:0]     sidx;
  logic [RW-1:0]     rec_idx;
  logic [RW-1:0]     cmp_idx;
  logic              rd_pend;

  logic [STAT_W-1:0] res_status;
  logic [2:0]        res_slot;
  logic              res_written;
  logic [DESC_W-1:0] res_desc;
  logic              res_dvalid;

  // unpacked input fields
  logic [SEG_W-1:0] in_seg;
  logic [1:0]       in_etype;
  logic [31:0]      in_addr;
  logic [3:0]       in_dom;
  logic [1:0]       in_ap;
  logic             in_c;
  logic             in_b;

  assign in_seg   = s_axis_tdata[11:0];
  assign in_etype = s_axis_tdata[13:12];
  assign in_addr  = s_axis_tdata[45:14];
  assign in_dom   = s_axis_tdata[49:46];
  assign in_ap    = s_axis_tdata[51:50];
  assign in_c     = s_axis_tdata[52];
  assign in_b     = s_axis_tdata[53];

  // record store
  logic              rec_valid;
  logic [SEG_W-1:0]  rec_seg;
  logic [DESC_W-1:0] rec_desc;
  logic              rec_wr;

  sstm_records #(
    .RECORDS (RECORDS),
    .RW      (RW)
  ) u_records (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (rec_idx),
    .rd_valid (rec_valid),
    .rd_seg   (rec_seg),
    .rd_desc  (rec_desc),
    .wr_en    (rec_wr),
    .wr_addr  (cmp_idx),
    .wr_seg   (seg),
    .wr_desc  (desc)
  );

  // slot table and round-robin pointer
  logic [SEG_W-1:0] slot_seg;
  logic [SW-1:0]    slot_ptr;
  logic             slot_take;

  sstm_slots #(
    .SLOTS (SLOTS),
    .SW    (SW)
  ) u_slots (
    .clk      (clk),
    .rst      (rst),
    .rd_idx   (sidx),
    .rd_seg   (slot_seg),
    .take     (slot_take),
    .take_seg (seg),
    .ptr      (slot_ptr)
  );

  // the one shared comparator: slot entry while checking residency, record otherwise
  logic [SEG_W-1:0] cmp_a;
  logic             seg_eq;
  assign cmp_a  = (state == S_SLOT) ? slot_seg : rec_seg;
  assign seg_eq = (cmp_a == seg);

  // register claims the first empty or matching record; reload needs a live match
  logic rec_hit;
  assign rec_hit = (kind == KIND_REGISTER) ? (!rec_valid || seg_eq) : (rec_valid && seg_eq);

  logic scan_hit;
  assign scan_hit = (state == S_REC) && rd_pend && rec_hit;
  assign rec_wr    = scan_hit && (kind == KIND_REGISTER);
  assign slot_take = scan_hit;

  // slot number reported on the 3-bit field
  logic [15:0] ptr_ext;
  assign ptr_ext = 16'(slot_ptr);

  logic out_free;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == S_IDLE) && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      rd_pend <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          rd_pend <= 1'b0;
          if (s_axis_tvalid) begin
            if (s_axis_tuser == KIND_RELOAD) begin
              state <= S_SLOT;
            end else if (in_seg == SEG_ZERO || in_seg == SEG_RESERVED) begin
              state <= S_DONE;
            end else begin
              state <= S_REC;
            end
          end
        end
        S_SLOT: begin
          if (seg_eq) begin
            state <= S_DONE;
          end else if (sidx == SLOT_LAST) begin
            state   <= S_REC;
            rd_pend <= 1'b0;
          end
        end
        S_REC: begin
          if (rd_pend && (rec_hit || cmp_idx == REC_LAST)) begin
            state   <= S_DONE;
            rd_pend <= 1'b0;
          end else begin
            rd_pend <= 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath: latched transaction, scan counters, result
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        kind    <= s_axis_tuser;
        seg     <= in_seg;
        desc    <= pack_desc(in_etype, in_addr, in_dom, in_ap, in_c, in_b);
        sidx    <= SLOT_ONE;
        rec_idx <= '0;
        // reserved-segment outcome, overwritten by any scan
        res_status  <= ST_SKIPPED;
        res_slot    <= '0;
        res_written <= 1'b0;
        res_desc    <= pack_desc(in_etype, in_addr, in_dom, in_ap, in_c, in_b);
        res_dvalid  <= 1'b1;
      end
      S_SLOT: begin
        if (seg_eq) begin
          res_status  <= ST_RESIDENT;
          res_slot    <= '0;
          res_written <= 1'b0;
          res_desc    <= '0;
          res_dvalid  <= 1'b0;
        end else if (sidx != SLOT_LAST) begin
          sidx <= sidx + SLOT_ONE;
        end
      end
      S_REC: begin
        cmp_idx <= rec_idx;
        if (rec_idx != REC_LAST) begin
          rec_idx <= rec_idx + RW'(1);
        end
        if (rd_pend) begin
          if (rec_hit) begin
            res_slot    <= ptr_ext[2:0];
            res_written <= 1'b1;
            res_dvalid  <= 1'b1;
            if (kind == KIND_REGISTER) begin
              res_status <= ST_REGISTERED;
              res_desc   <= desc;
            end else begin
              res_status <= ST_RELOADED;
              res_desc   <= rec_desc;
            end
          end else if (cmp_idx == REC_LAST) begin
            res_slot    <= '0;
            res_written <= 1'b0;
            if (kind == KIND_REGISTER) begin
              res_status <= ST_FULL;
              res_desc   <= desc;
              res_dvalid <= 1'b1;
            end else begin
              res_status <= ST_NOT_FOUND;
              res_desc   <= '0;
              res_dvalid <= 1'b0;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      m_axis_tdata <= {3'b000, res_dvalid, res_desc, res_written, res_slot};
      m_axis_tuser <= res_status;
    end
  end

  // checks
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    slot_ptr != '0 && slot_ptr <= SLOT_LAST)
    else $error("slot pointer out of range");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second transaction taken while busy");

  a_registered_fields: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == ST_REGISTERED |-> m_axis_tdata[3] && m_axis_tdata[36])
    else $error("registered result without slot or descriptor write");

  a_resident_quiet: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == ST_RESIDENT || m_axis_tuser == ST_NOT_FOUND)
    |-> !m_axis_tdata[3] && !m_axis_tdata[36])
    else $error("reload without change reports a write");

  a_take_in_scan: assert property (@(posedge clk) disable iff (rst)
    slot_take |-> state == S_REC && rd_pend)
    else $error("slot taken outside record scan");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import sstm_pkg::*;

  localparam int NREC        = RECORDS_DEF;
  localparam int NSLOT       = SLOTS_DEF;
  localparam int POOL        = 10;
  // cycles with no transaction on either side before the run is declared hung
  localparam int QUIET_LIMIT = 3000;
  // settle time after the drain, to catch any stray late result
  localparam int TAIL_CYCLES = 40;
  localparam int MAX_PRINTS  = 100;

  localparam logic [15:0] EMPTY_RECORD = 16'hFFFF;

  // one input transaction, unpacked
  typedef struct {
    logic        kind;
    logic [11:0] seg;
    logic [1:0]  etype;
    logic [31:0] addr;
    logic [3:0]  dom;
    logic [1:0]  ap;
    logic        c;
    logic        b;
  } seg_request_t;

  // one result transaction, unpacked
  typedef struct {
    logic [2:0]  status;
    logic [2:0]  slot;
    logic        slot_wr;
    logic [31:0] desc;
    logic        desc_vld;
  } seg_outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  // predictor state: segment records, slot contents, round-robin pointer
  logic [15:0] rec_seg  [NREC];
  logic [31:0] rec_desc [NREC];
  logic [11:0] slot_seg [NSLOT];
  int unsigned slot_ptr;

  seg_outcome_t pending_outcomes[$];
  logic [11:0]  seg_pool[POOL];

  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  segment_slot_translation_manager dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_tables();
    for (int i = 0; i < NREC; i++) begin
      rec_seg[i]  = EMPTY_RECORD;
      rec_desc[i] = '0;
    end
    for (int i = 0; i < NSLOT; i++) slot_seg[i] = '0;
    slot_ptr = 1;
  endfunction

  // First-level descriptor: [1:0] type, [4] one unless invalid, [8:5] domain.
  // Section adds AP at [11:10], C at [3], B at [2]; base alignment per type.
  function automatic logic [31:0] build_descriptor(seg_request_t r);
    logic [31:0] d;
    case (r.etype)
      ET_COARSE:  d = {r.addr[31:10], 1'b0, r.dom, 1'b1, 4'b0001};
      ET_SECTION: d = {r.addr[31:20], 8'd0, r.ap, 1'b0, r.dom, 1'b1, r.c, r.b, 2'b10};
      ET_FINE:    d = {r.addr[31:12], 3'd0, r.dom, 1'b1, 4'b0011};
      default:    d = '0;
    endcase
    return d;
  endfunction

  // round-robin over slots 1..NSLOT-1; slot 0 stays pinned to segment 0
  function automatic logic [2:0] claim_slot(logic [11:0] seg);
    int unsigned s;
    s = slot_ptr;
    if (s == 0 || s >= NSLOT) s = 1;
    slot_seg[s] = seg;
    slot_ptr = s + 1;
    if (slot_ptr > NSLOT - 1) slot_ptr = 1;
    return s[2:0];
  endfunction

  function automatic seg_outcome_t predict_outcome(seg_request_t r);
    seg_outcome_t o;
    int hit;
    bit resident;
    o.status   = '0;
    o.slot     = '0;
    o.slot_wr  = 1'b0;
    o.desc     = '0;
    o.desc_vld = 1'b0;
    hit = -1;
    resident = 1'b0;
    if (r.kind == KIND_REGISTER) begin
      // descriptor goes out even when nothing is recorded
      o.desc     = build_descriptor(r);
      o.desc_vld = 1'b1;
      if (r.seg == SEG_ZERO || r.seg == SEG_RESERVED) begin
        o.status = ST_SKIPPED;
      end else begin
        // first record that is empty or already owns this segment
        for (int i = 0; i < NREC; i++)
          if (hit < 0 && (rec_seg[i] == EMPTY_RECORD || rec_seg[i] == {4'h0, r.seg}))
            hit = i;
        if (hit < 0) begin
          o.status = ST_FULL;
        end else begin
          rec_seg[hit]  = {4'h0, r.seg};
          rec_desc[hit] = o.desc;
          o.slot        = claim_slot(r.seg);
          o.slot_wr     = 1'b1;
          o.status      = ST_REGISTERED;
        end
      end
    end else begin
      for (int i = 1; i < NSLOT; i++)
        if (slot_seg[i] == r.seg) resident = 1'b1;
      if (resident) begin
        o.status = ST_RESIDENT;
      end else begin
        o.status = ST_NOT_FOUND;
        for (int i = 0; i < NREC; i++)
          if (hit < 0 && rec_seg[i] == {4'h0, r.seg}) hit = i;
        if (hit >= 0) begin
          o.slot     = claim_slot(r.seg);
          o.slot_wr  = 1'b1;
          o.desc     = rec_desc[hit];
          o.desc_vld = 1'b1;
          o.status   = ST_RELOADED;
        end
      end
    end
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking and receiver back-pressure
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  // Outputs are read right after the edge, before any NBA of this step lands,
  // so tvalid/tready/tdata are the values the DUT saw at the edge.
  always @(posedge clk) begin
    seg_outcome_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("result with nothing pending", {29'd0, m_axis_tuser}, '0);
      end else begin
        want = pending_outcomes.pop_front();
        if (m_axis_tuser !== want.status)
          report_mismatch("status", {29'd0, m_axis_tuser}, {29'd0, want.status});
        if (m_axis_tdata[2:0] !== want.slot)
          report_mismatch("slot", {29'd0, m_axis_tdata[2:0]}, {29'd0, want.slot});
        if (m_axis_tdata[3] !== want.slot_wr)
          report_mismatch("slot_written", {31'd0, m_axis_tdata[3]}, {31'd0, want.slot_wr});
        if (m_axis_tdata[35:4] !== want.desc)
          report_mismatch("descriptor", m_axis_tdata[35:4], want.desc);
        if (m_axis_tdata[36] !== want.desc_vld)
          report_mismatch("descriptor_valid", {31'd0, m_axis_tdata[36]},
                          {31'd0, want.desc_vld});
        if (m_axis_tdata[39:37] !== 3'd0)
          report_mismatch("pad bits", {29'd0, m_axis_tdata[39:37]}, '0);
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // hang detection: any accepted transaction on either side resets the count
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** segment_slot_translation_manager: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Holds tvalid high after acceptance, so back-to-back sends with no idle
  // gaps never drop it; release_input lowers it when a phase ends.
  task automatic send_item(input seg_request_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.kind;
    s_axis_tdata  <= {2'b00, r.b, r.c, r.ap, r.dom, r.addr, r.etype, r.seg};
    do @(posedge clk); while (!s_axis_tready);
    pending_outcomes.push_back(predict_outcome(r));
  endtask

  task automatic release_input();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic issue(input logic kind, input logic [11:0] seg, input logic [1:0] etype,
                       input logic [31:0] addr, input logic [3:0] dom,
                       input logic [1:0] ap, input logic c, input logic b);
    seg_request_t r;
    r.kind  = kind;
    r.seg   = seg;
    r.etype = etype;
    r.addr  = addr;
    r.dom   = dom;
    r.ap    = ap;
    r.c     = c;
    r.b     = b;
    send_item(r);
  endtask

  // Mostly a small pool of segments so registrations are followed by reloads,
  // resident hits and evictions; some reserved and fully random segments too.
  // The random ones fill the record table, after which new segments are refused.
  function automatic seg_request_t random_request();
    seg_request_t r;
    int pick;
    pick    = $urandom_range(99);
    r.kind  = 1'($urandom_range(1));
    if (pick < 70)      r.seg = seg_pool[$urandom_range(POOL - 1)];
    else if (pick < 78) r.seg = $urandom_range(1) ? SEG_RESERVED : SEG_ZERO;
    else                r.seg = 12'($urandom_range(12'hFFF));
    r.etype = 2'($urandom_range(3));
    r.addr  = $urandom;
    r.dom   = 4'($urandom_range(15));
    r.ap    = 2'($urandom_range(3));
    r.c     = 1'($urandom_range(1));
    r.b     = 1'($urandom_range(1));
    return r;
  endfunction

  task automatic run_random(input int count, input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_item(random_request());
    release_input();
  endtask

  // Reserved segments, every entry type at field extremes, known-segment
  // update, pointer wrap, eviction then reload, resident and not-found cases.
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // all slots hold segment 0 after reset, so segment 0 is resident
    issue(KIND_RELOAD,   SEG_ZERO,     ET_INVALID, '0, '0, '0, 1'b0, 1'b0);
    issue(KIND_RELOAD,   SEG_RESERVED, ET_INVALID, '0, '0, '0, 1'b0, 1'b0);
    issue(KIND_RELOAD,   12'hFFF,      ET_FINE,    '1, '1, '1, 1'b1, 1'b1);
    // reserved segments: descriptor out, tables untouched
    issue(KIND_REGISTER, SEG_ZERO,     ET_SECTION, '1, '1, '1, 1'b1, 1'b1);
    issue(KIND_REGISTER, SEG_RESERVED, ET_COARSE,  '1, '1, '1, 1'b1, 1'b1);
    // fill slots 1..7
    issue(KIND_REGISTER, 12'h001, ET_COARSE,  '1, '1, '0, 1'b0, 1'b0);
    issue(KIND_REGISTER, 12'hFFF, ET_FINE,    '1, '1, '1, 1'b1, 1'b1);
    issue(KIND_REGISTER, 12'h002, ET_SECTION, '1, '1, '1, 1'b1, 1'b1);
    issue(KIND_REGISTER, 12'h003, ET_SECTION, '0, '0, '0, 1'b0, 1'b0);
    issue(KIND_REGISTER, 12'h004, ET_INVALID, '1, '1, '1, 1'b1, 1'b1);
    issue(KIND_REGISTER, 12'h005, ET_FINE,    '0, '0, '0, 1'b0, 1'b0);
    issue(KIND_REGISTER, 12'h006, ET_COARSE,  '0, '0, '0, 1'b0, 1'b0);
    // known segment: record rewritten, pointer wraps back to slot 1
    issue(KIND_REGISTER, 12'h001, ET_SECTION, 32'h1234_5678, 4'hA, 2'd2, 1'b1, 1'b0);
    issue(KIND_RELOAD,   12'h001, ET_INVALID, '0, '0, '0, 1'b0, 1'b0);
    // segment 0 no longer in any of slots 1..7 and has no record
    issue(KIND_RELOAD,   SEG_ZERO, ET_INVALID, '0, '0, '0, 1'b0, 1'b0);
    issue(KIND_RELOAD,   12'hFFF,  ET_INVALID, '0, '0, '0, 1'b0, 1'b0);
    // evict 0xFFF, then bring it back from its record
    issue(KIND_REGISTER, 12'h008, ET_FINE,    32'hA5A5_A5A5, 4'h5, 2'd1, 1'b0, 1'b1);
    issue(KIND_RELOAD,   12'hFFF, ET_INVALID, '0, '0, '0, 1'b0, 1'b0);
    issue(KIND_RELOAD,   12'h009, ET_INVALID, '0, '0, '0, 1'b0, 1'b0);
    release_input();
  endtask

  task automatic test_back_to_back();
    run_random(150, 0, 0);
  endtask

  task automatic test_sender_gaps();
    run_random(150, 83, 0);
  endtask

  task automatic test_receiver_stalls();
    run_random(150, 0, 83);
  endtask

  task automatic test_both_sides_idle();
    run_random(150, 23, 23);
  endtask

  initial begin
    clear_tables();
    for (int i = 0; i < POOL; i++) seg_pool[i] = 12'($urandom_range(12'hFFF));
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_back_to_back();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_sides_idle();

    // drain, then allow for any stray late result
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("** segment_slot_translation_manager: PASSED **");
    end else begin
      $display("** segment_slot_translation_manager: FAILED **");
    end
    $finish;
  end

endmodule

// ===== segment_slot_translation_manager.f =====
hdl/sstm_pkg.sv
hdl/sstm_records.sv
hdl/sstm_slots.sv
hdl/segment_slot_translation_manager.sv
dv/tb.sv
